// ===== src/ima_pkg.sv =====
package ima_pkg;

    localparam int NODES      = 1024;
    localparam int MAX_DEGREE = 8;
    localparam int NODE_W     = 10;
    localparam int SLOT_W     = 3;
    localparam int EDGE_AW    = NODE_W + SLOT_W;
    localparam int EDGES      = NODES * MAX_DEGREE;
    localparam int WEIGHT_W   = 16;
    localparam int EPOCH_W    = 32;
    // Eight negated most-negative weights reach one past the signed range of
    // WEIGHT_W + SLOT_W bits, so the slot sum carries one extra bit.
    localparam int NSUM_W     = WEIGHT_W + SLOT_W + 1;
    localparam int DE_W       = NSUM_W + 1;
    localparam int BIG_W      = 32;
    localparam int PROD_W     = 16 + NSUM_W;

    localparam logic [2:0] REQ_EDGE   = 3'd0;
    localparam logic [2:0] REQ_SPIN   = 3'd1;
    localparam logic [2:0] REQ_ENERGY = 3'd2;
    localparam logic [2:0] REQ_TRIAL  = 3'd3;
    localparam logic [2:0] REQ_BEST   = 3'd4;

    localparam logic [15:0] BETA_RESET = 16'd4096;
    localparam logic [12:0] LOG2E_Q12  = 13'd5909;

    localparam logic [15:0] POW2 [16] = '{
        16'd65535, 16'd62757, 16'd60097, 16'd57549,
        16'd55109, 16'd52773, 16'd50535, 16'd48393,
        16'd46341, 16'd44376, 16'd42494, 16'd40693,
        16'd38968, 16'd37316, 16'd35733, 16'd34219
    };

    typedef struct packed {
        logic [2:0]          req_type;
        logic [NODE_W-1:0]   node;
        logic [SLOT_W-1:0]   slot;
        logic [NODE_W-1:0]   neighbour;
        logic signed [15:0]  coupling;
        logic                slot_used;
        logic                spin_value;
        logic [15:0]         uniform;
    } t_req;

    typedef struct packed {
        logic                flipped;
        logic signed [31:0]  energy_now;
        logic signed [31:0]  energy_best;
        logic                spin_out;
    } t_res;

    typedef struct packed {
        logic                 valid;
        logic [NODE_W-1:0]    target;
        logic [WEIGHT_W-1:0]  weight;
    } t_edge;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic               best;
        logic               cur;
    } t_spin_ent;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_EDGE_WR, ST_SPIN_RD, ST_SPIN_WR, ST_BEST_RD,
        ST_BEST_OUT, ST_NODE_RD, ST_NODE_DAT, ST_EDGE_RD, ST_EDGE_DAT,
        ST_NBR_DAT, ST_NODE_END, ST_MUL1, ST_MUL2, ST_DECIDE, ST_ENERGY,
        ST_TRACK, ST_EFIN, ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic edge_wr;
        logic spin_rd_nbr;
        logic latch_node;
        logic latch_edge;
        logic accum;
        logic node_end;
        logic spin_wr_load;
        logic best_out;
        logic mul1;
        logic mul2;
        logic decide;
        logic energy;
        logic track;
        logic efin;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic slot_last;
        logic node_last;
        logic energy_mode;
    } t_status;

endpackage

// ===== src/ima_ram.sv =====
module ima_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/ima_ctrl.sv =====
module ima_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic [2:0]      i_req_type,
    input  ima_pkg::t_status i_status,
    output ima_pkg::t_cmd   o_cmd,
    output logic            busy,
    output logic            o_done
);
    import ima_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = (r_state != ST_IDLE);
        o_done  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    case (i_req_type)
                        REQ_EDGE:   n_state = ST_EDGE_WR;
                        REQ_SPIN:   n_state = ST_SPIN_RD;
                        REQ_ENERGY: n_state = ST_NODE_RD;
                        REQ_TRIAL:  n_state = ST_NODE_RD;
                        REQ_BEST:   n_state = ST_BEST_RD;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_EDGE_WR: begin
                o_cmd.edge_wr = 1'b1;
                n_state = ST_DONE;
            end
            ST_SPIN_RD:  n_state = ST_SPIN_WR;
            ST_SPIN_WR: begin
                o_cmd.spin_wr_load = 1'b1;
                n_state = ST_DONE;
            end
            ST_BEST_RD:  n_state = ST_BEST_OUT;
            ST_BEST_OUT: begin
                o_cmd.best_out = 1'b1;
                n_state = ST_DONE;
            end
            ST_NODE_RD:  n_state = ST_NODE_DAT;
            ST_NODE_DAT: begin
                o_cmd.latch_node = 1'b1;
                n_state = ST_EDGE_RD;
            end
            ST_EDGE_RD:  n_state = ST_EDGE_DAT;
            ST_EDGE_DAT: begin
                o_cmd.latch_edge  = 1'b1;
                o_cmd.spin_rd_nbr = 1'b1;
                n_state = ST_NBR_DAT;
            end
            ST_NBR_DAT: begin
                o_cmd.accum = 1'b1;
                n_state = i_status.slot_last ? ST_NODE_END : ST_EDGE_RD;
            end
            ST_NODE_END: begin
                o_cmd.node_end = 1'b1;
                if (!i_status.energy_mode) begin
                    n_state = ST_MUL1;
                end else if (i_status.node_last) begin
                    n_state = ST_EFIN;
                end else begin
                    n_state = ST_NODE_RD;
                end
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = ST_ENERGY;
            end
            ST_ENERGY: begin
                o_cmd.energy = 1'b1;
                n_state = ST_TRACK;
            end
            ST_TRACK: begin
                o_cmd.track = 1'b1;
                n_state = ST_DONE;
            end
            ST_EFIN: begin
                o_cmd.efin = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== src/ima_dp.sv =====
module ima_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ima_pkg::t_req    i_req,
    input  ima_pkg::t_cmd    i_cmd,
    input  logic             i_cfg_valid,
    input  logic [15:0]      i_cfg_data,
    output ima_pkg::t_status o_status,
    output ima_pkg::t_res    o_res
);
    import ima_pkg::*;

    t_req                     r_req;
    logic [15:0]              r_beta;
    logic [EDGE_AW-1:0]       r_clr_cnt;
    logic [SLOT_W-1:0]        r_slot;
    logic [NODE_W-1:0]        r_node_cnt;
    logic [EPOCH_W-1:0]       r_snap;
    logic signed [31:0]       r_total;
    logic signed [31:0]       r_lowest;
    logic                     r_flipped;
    logic                     r_spin_out;
    logic                     r_si;
    t_spin_ent                r_ent;
    t_edge                    r_edge;
    logic signed [NSUM_W-1:0] r_ns;
    logic signed [BIG_W-1:0]  r_big;
    logic signed [DE_W-1:0]   r_de;
    logic                     r_neg;
    logic [PROD_W-1:0]        r_p;
    logic [17:0]              r_y;
    logic                     r_pbig;
    logic                     r_pzero;

    logic [NODE_W-1:0]        node_sel;
    logic                     energy_mode;
    t_edge                    edge_rd;
    t_edge                    edge_wdata;
    logic                     edge_we;
    logic [EDGE_AW-1:0]       edge_waddr;
    t_spin_ent                spin_rd;
    t_spin_ent                spin_wdata;
    logic                     spin_we;
    logic [NODE_W-1:0]        spin_waddr;
    logic [NODE_W-1:0]        spin_raddr;
    logic                     eff_best;
    logic                     ent_best;
    logic signed [NSUM_W-1:0] wext;
    logic signed [DE_W-1:0]   ns_ext;
    logic [29:0]              y_prod;
    logic [5:0]               n_sh;
    logic [15:0]              pow_sh;
    logic                     accept_flip;
    logic signed [32:0]       e_sum;
    logic signed [31:0]       e_sat;

    assign energy_mode = (r_req.req_type == REQ_ENERGY);
    assign node_sel    = energy_mode ? r_node_cnt : r_req.node;

    // A node's best-state spin equals its current spin once a snapshot has
    // been taken after its last write; otherwise the stored copy holds.
    assign eff_best = (spin_rd.epoch != r_snap) ? spin_rd.cur : spin_rd.best;
    assign ent_best = (r_ent.epoch != r_snap) ? r_ent.cur : r_ent.best;

    assign edge_we    = i_cmd.clr_wr | i_cmd.edge_wr;
    assign edge_waddr = i_cmd.clr_wr ? r_clr_cnt : {r_req.node, r_req.slot};
    always_comb begin
        edge_wdata = '0;
        if (!i_cmd.clr_wr) begin
            edge_wdata.valid  = r_req.slot_used;
            edge_wdata.target = r_req.neighbour;
            edge_wdata.weight = r_req.coupling;
        end
    end

    ima_ram #(.WIDTH($bits(t_edge)), .DEPTH(EDGES)) u_edge_ram (
        .i_clk  (i_clk),
        .i_we   (edge_we),
        .i_waddr(edge_waddr),
        .i_wdata(edge_wdata),
        .i_raddr({node_sel, r_slot}),
        .o_rdata(edge_rd)
    );

    // Trial flip writes the inverted spin; a load writes the requested one.
    always_comb begin
        spin_we    = i_cmd.clr_wr | i_cmd.spin_wr_load | (i_cmd.decide & accept_flip);
        spin_waddr = i_cmd.clr_wr ? r_clr_cnt[NODE_W-1:0] : node_sel;
        spin_wdata = '0;
        if (i_cmd.spin_wr_load) begin
            spin_wdata.epoch = r_snap;
            spin_wdata.best  = eff_best;
            spin_wdata.cur   = r_req.spin_value;
        end else if (!i_cmd.clr_wr) begin
            spin_wdata.epoch = r_snap;
            spin_wdata.best  = ent_best;
            spin_wdata.cur   = ~r_si;
        end
    end

    assign spin_raddr = i_cmd.spin_rd_nbr ? edge_rd.target : node_sel;

    ima_ram #(.WIDTH($bits(t_spin_ent)), .DEPTH(NODES)) u_spin_ram (
        .i_clk  (i_clk),
        .i_we   (spin_we),
        .i_waddr(spin_waddr),
        .i_wdata(spin_wdata),
        .i_raddr(spin_raddr),
        .o_rdata(spin_rd)
    );

    assign wext   = NSUM_W'($signed(r_edge.weight));
    assign ns_ext = DE_W'(r_ns);
    assign y_prod = r_p[16:0] * LOG2E_Q12;
    assign n_sh   = r_y[17:12];
    assign pow_sh = POW2[r_y[11:8]] >> n_sh;
    assign accept_flip = r_neg | r_pzero |
                         (!r_pbig && (n_sh <= 6'd16) && (pow_sh > r_req.uniform));
    assign e_sum  = 33'(r_total) + 33'(r_de);
    always_comb begin
        if (e_sum[32] != e_sum[31]) begin
            e_sat = e_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            e_sat = e_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta     <= BETA_RESET;
            r_clr_cnt  <= '0;
            r_slot     <= '0;
            r_node_cnt <= '0;
            r_snap     <= '0;
            r_total    <= '0;
            r_lowest   <= '0;
            r_flipped  <= 1'b0;
            r_spin_out <= 1'b0;
        end else begin
            if (i_cfg_valid) r_beta <= i_cfg_data;
            if (i_cmd.clr_wr) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (i_cmd.accept) begin
                r_flipped  <= 1'b0;
                r_spin_out <= 1'b0;
                r_slot     <= '0;
                r_node_cnt <= '0;
            end
            if (i_cmd.accum) r_slot <= r_slot + 1'b1;
            if (i_cmd.node_end) r_node_cnt <= r_node_cnt + 1'b1;
            if (i_cmd.best_out) r_spin_out <= eff_best;
            if (i_cmd.decide && accept_flip) r_flipped <= 1'b1;
            if (i_cmd.energy && r_flipped) r_total <= e_sat;
            if (i_cmd.track && (r_total < r_lowest)) begin
                r_lowest <= r_total;
                r_snap   <= r_snap + 1'b1;
            end
            if (i_cmd.efin) begin
                r_total  <= r_big >>> 1;
                r_lowest <= r_big >>> 1;
                r_snap   <= r_snap + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req;
            r_ns  <= '0;
            r_big <= '0;
        end
        if (i_cmd.latch_node) begin
            r_si  <= spin_rd.cur;
            r_ent <= spin_rd;
        end
        if (i_cmd.latch_edge) r_edge <= edge_rd;
        if (i_cmd.accum && r_edge.valid) begin
            r_ns <= spin_rd.cur ? r_ns + wext : r_ns - wext;
        end
        if (i_cmd.node_end) begin
            r_ns  <= '0;
            r_big <= r_si ? r_big - BIG_W'(r_ns) : r_big + BIG_W'(r_ns);
            r_de  <= r_si ? (ns_ext <<< 1) : -(ns_ext <<< 1);
        end
        if (i_cmd.mul1) begin
            r_neg <= r_de[DE_W-1];
            r_p   <= r_beta * r_de[DE_W-2:0];
        end
        if (i_cmd.mul2) begin
            r_y     <= y_prod[29:12];
            r_pbig  <= (r_p[PROD_W-1:17] != '0);
            r_pzero <= (r_p == '0);
        end
    end

    assign o_status.clr_last    = (r_clr_cnt == EDGE_AW'(EDGES - 1));
    assign o_status.slot_last   = (r_slot == SLOT_W'(MAX_DEGREE - 1));
    assign o_status.node_last   = (r_node_cnt == NODE_W'(NODES - 1));
    assign o_status.energy_mode = energy_mode;

    assign o_res.flipped     = r_flipped;
    assign o_res.energy_now  = r_total;
    assign o_res.energy_best = r_lowest;
    assign o_res.spin_out    = r_spin_out;
endmodule

// ===== src/ising_metropolis_annealer.sv =====
// One item at a time. A trial walks eight neighbour slots, each through the edge read, edge
// data and neighbour data states of the single-read memories, then node end, multiply, decide,
// energy and track. Edge and spin writes, best-spin reads and no-op requests skip the neighbour
// walk; an energy compute walks all edges of all nodes.
// A clearing pass over all edge slots and spin entries follows reset with busy high; beta resets to 1.0.
// Each result shows for one cycle with o_done; the receiver cannot stall it.
module ising_metropolis_annealer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ima_pkg::t_req  i_req,
    output logic           o_done,
    output ima_pkg::t_res  o_res,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [15:0]    i_cfg_data
);
    import ima_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    ima_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_req_type(i_req.req_type),
        .i_status  (status),
        .o_cmd     (cmd),
        .busy      (busy),
        .o_done    (o_done)
    );

    ima_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .i_cfg_valid(i_cfg_valid & o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_status   (status),
        .o_res      (o_res)
    );
endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ima_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam logic [2:0] REQ_NONE5 = 3'd5;
    localparam logic [2:0] REQ_NONE7 = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_done;
    t_res        o_res;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    ising_metropolis_annealer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_done(o_done), .o_res(o_res),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the annealer state.
    bit          spin_now [NODES];
    bit          spin_best [NODES];
    bit [9:0]    edge_dst [EDGES];
    longint      edge_w [EDGES];
    bit          edge_on [EDGES];
    longint      energy_cur;
    longint      energy_low;
    bit [15:0]   beta;

    t_req        pending_items [$];
    t_res        expected_results [$];
    int          errors = 0;
    int          cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          energy_runs = 0;

    task automatic report(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    function automatic longint spin_sign(input int n);
        return spin_now[n] ? 64'sd1 : -64'sd1;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic bit metropolis_accept(input longint de, input bit [15:0] u);
        bit [63:0] p;
        bit [63:0] y;
        bit [63:0] n;
        bit [63:0] k;
        if (de < 0) return 1'b1;
        p = 64'(beta) * 64'(de);
        if (p == 0) return 1'b1;
        if (p >= (64'd1 << 40)) return 1'b0;
        y = (p * 64'd5909) >> 12;
        n = y >> 12;
        if (n > 16) return 1'b0;
        k = (y >> 8) & 64'd15;
        return (64'(POW2[k]) >> n) > 64'(u);
    endfunction

    function automatic t_res predict_item(input t_req r);
        t_res   res;
        longint sum;
        longint de;
        int     e;
        res = '0;
        sum = 0;
        case (r.req_type)
            REQ_EDGE: begin
                e = int'(r.node) * MAX_DEGREE + int'(r.slot);
                edge_dst[e] = r.neighbour;
                edge_w[e] = longint'($signed(r.coupling));
                edge_on[e] = r.slot_used;
            end
            REQ_SPIN: spin_now[r.node] = r.spin_value;
            REQ_ENERGY: begin
                for (int i = 0; i < NODES; i++)
                    for (int s = 0; s < MAX_DEGREE; s++) begin
                        e = i * MAX_DEGREE + s;
                        if (edge_on[e])
                            sum -= edge_w[e] * spin_sign(i) * spin_sign(edge_dst[e]);
                    end
                // Arithmetic shift halves with rounding toward minus infinity.
                energy_cur = clamp32(sum >>> 1);
                energy_low = energy_cur;
                spin_best = spin_now;
            end
            REQ_TRIAL: begin
                for (int s = 0; s < MAX_DEGREE; s++) begin
                    e = int'(r.node) * MAX_DEGREE + s;
                    if (edge_on[e]) sum += edge_w[e] * spin_sign(edge_dst[e]);
                end
                de = 2 * spin_sign(r.node) * sum;
                if (metropolis_accept(de, r.uniform)) begin
                    res.flipped = 1'b1;
                    spin_now[r.node] = ~spin_now[r.node];
                    energy_cur = clamp32(energy_cur + de);
                end
                if (energy_cur < energy_low) begin
                    energy_low = energy_cur;
                    spin_best = spin_now;
                end
            end
            REQ_BEST: res.spin_out = spin_best[r.node];
            default: ;
        endcase
        res.energy_now = energy_cur[31:0];
        res.energy_best = energy_low[31:0];
        return res;
    endfunction

    // Result check and prediction share one edge so their order is fixed.
    always @(posedge i_clk) begin
        t_res want;
        cycles++;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                report("result with no item outstanding");
            end else begin
                want = expected_results.pop_front();
                if (o_res.flipped !== want.flipped)
                    report($sformatf("flipped %b want %b", o_res.flipped, want.flipped));
                if (o_res.energy_now !== want.energy_now)
                    report($sformatf("energy_now %0d want %0d",
                                     o_res.energy_now, want.energy_now));
                if (o_res.energy_best !== want.energy_best)
                    report($sformatf("energy_best %0d want %0d",
                                     o_res.energy_best, want.energy_best));
                if (o_res.spin_out !== want.spin_out)
                    report($sformatf("spin_out %b want %b", o_res.spin_out, want.spin_out));
            end
        end
        if (i_rst_n && start && !busy) begin
            expected_results.push_back(predict_item(i_req));
            void'(pending_items.pop_front());
            if (burst_left > 0) burst_left--;
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sender: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n || pending_items.size() == 0) begin
            start <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
        end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            start <= 1'b0;
        end else begin
            start <= 1'b1;
            i_req <= pending_items[0];
        end
    end

    function automatic t_req make_item(input logic [2:0] kind, input int node, input int slot,
                                       input int nb, input int w, input bit used,
                                       input bit sp, input int u);
        t_req r;
        r.req_type = kind;
        r.node = node[9:0];
        r.slot = slot[2:0];
        r.neighbour = nb[9:0];
        r.coupling = w[15:0];
        r.slot_used = used;
        r.spin_value = sp;
        r.uniform = u[15:0];
        return r;
    endfunction

    task automatic drain();
        while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_beta(input bit [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        beta = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random traffic centered on a small cluster so trials see real edges.
    task automatic random_phase(input int count);
        int base;
        int node;
        int pick;
        base = $urandom_range(0, 1008);
        for (int i = 0; i < count; i++) begin
            node = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                               : base + $urandom_range(0, 15);
            pick = $urandom_range(0, 99);
            if (pick < 25)
                pending_items.push_back(make_item(REQ_EDGE, node, $urandom_range(0, 7),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                : base + $urandom_range(0, 15),
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400) - 200,
                    $urandom_range(0, 5) != 0, $urandom_range(0, 1), $urandom));
            else if (pick < 35)
                pending_items.push_back(make_item(REQ_SPIN, node, $urandom, $urandom,
                    $urandom, $urandom_range(0, 1), $urandom_range(0, 1), $urandom));
            else if (pick < 83)
                pending_items.push_back(make_item(REQ_TRIAL, node, $urandom, $urandom,
                    $urandom, $urandom_range(0, 1), $urandom_range(0, 1), $urandom));
            else if (pick < 95)
                pending_items.push_back(make_item(REQ_BEST, node, $urandom, $urandom,
                    $urandom, $urandom_range(0, 1), $urandom_range(0, 1), $urandom));
            else if (pick < 97 && energy_runs < 10) begin
                energy_runs++;
                pending_items.push_back(make_item(REQ_ENERGY, node, $urandom, $urandom,
                    $urandom, $urandom_range(0, 1), $urandom_range(0, 1), $urandom));
            end else
                pending_items.push_back(make_item(3'($urandom_range(5, 7)), node, $urandom,
                    $urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1),
                    $urandom));
        end
    endtask

    initial begin
        bit [15:0] betas [6];
        betas = '{16'd4096, 16'd0, 16'd65535, 16'd1, 16'd512, 16'd8192};
        spin_now = '{default: 1'b0};
        spin_best = '{default: 1'b0};
        edge_dst = '{default: '0};
        edge_w = '{default: 0};
        edge_on = '{default: 1'b0};
        energy_cur = 0;
        energy_low = 0;
        beta = BETA_RESET;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: weight extremes, slot and node extremes, self loop, slot clear,
        // trials at both threshold ends, energy compute and two of the unused codes.
        pending_items.push_back(make_item(REQ_EDGE, 0, 0, 1, -32768, 1, 0, 0));
        pending_items.push_back(make_item(REQ_EDGE, 1, 7, 0, 32767, 1, 1, 65535));
        pending_items.push_back(make_item(REQ_EDGE, 1023, 7, 1023, 32767, 1, 0, 0));
        pending_items.push_back(make_item(REQ_EDGE, 1023, 0, 0, -1, 1, 1, 0));
        pending_items.push_back(make_item(REQ_EDGE, 0, 3, 1023, 100, 1, 0, 0));
        pending_items.push_back(make_item(REQ_EDGE, 0, 3, 1023, 100, 0, 0, 0));
        pending_items.push_back(make_item(REQ_SPIN, 1, 0, 0, 0, 0, 1, 0));
        pending_items.push_back(make_item(REQ_SPIN, 1023, 0, 0, 0, 0, 1, 0));
        pending_items.push_back(make_item(REQ_ENERGY, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(REQ_TRIAL, 0, 0, 0, 0, 0, 0, 65535));
        pending_items.push_back(make_item(REQ_TRIAL, 1, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(REQ_TRIAL, 1023, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(REQ_TRIAL, 512, 0, 0, 0, 0, 0, 65535));
        pending_items.push_back(make_item(REQ_BEST, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(REQ_BEST, 1023, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(REQ_NONE5, 1023, 7, 1023, -1, 1, 1, 65535));
        pending_items.push_back(make_item(REQ_NONE7, 0, 0, 0, 0, 0, 0, 0));
        drain();

        foreach (betas[p]) begin
            write_beta(betas[p]);
            pending_items.push_back(make_item(REQ_TRIAL, 1, 0, 0, 0, 0, 0, 0));
            pending_items.push_back(make_item(REQ_TRIAL, 0, 0, 0, 0, 0, 0, 65535));
            random_phase(130);
            drain();
        end
        write_beta(16'($urandom));
        random_phase(40);
        drain();
        repeat (50) @(posedge i_clk);

        if (expected_results.size() != 0) report("results never arrived");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
